[rtl/core/stc_pkg.sv]
// Package for the space token classifier.
// Holds the word tables, token class codes and the shared token struct.
// No dependencies.
package stc_pkg;

    localparam int NRes = 4;
    localparam int NSym = 8;

    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [7:0] DIGIT_LO   = 8'd48;
    localparam logic [7:0] DIGIT_HI   = 8'd57;

    localparam logic [2:0] CLS_RESERVED = 3'd0;
    localparam logic [2:0] CLS_SYMBOL   = 3'd1;
    localparam logic [2:0] CLS_NUMBER   = 3'd2;
    localparam logic [2:0] CLS_NOT_ID   = 3'd3;
    localparam logic [2:0] CLS_IDENT    = 3'd4;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // Reserved words, first character in the low byte: cout<<, for, int, while
    localparam logic [63:0] RES_STR [NRes] = '{
        64'h0000_3C3C_7475_6F63,
        64'h0000_0000_0072_6F66,
        64'h0000_0000_0074_6E69,
        64'h0000_0065_6C69_6877
    };
    localparam logic [2:0] RES_LEN [NRes] = '{3'd6, 3'd3, 3'd3, 3'd5};

    // Special symbols: = * - ; ( ) <= +
    localparam logic [15:0] SYM_STR [NSym] = '{
        16'h003D, 16'h002A, 16'h002D, 16'h003B,
        16'h0028, 16'h0029, 16'h3D3C, 16'h002B
    };
    localparam logic [1:0] SYM_LEN [NSym] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1
    };

    // Finished token handed from the token tracker to the output stage
    typedef struct packed {
        logic [2:0] token_class;
        logic [7:0] token_length;
    } t_token;

endpackage

[rtl/core/stc_token_state.sv]
// Running token tracker: length counter, prefix match flags and digit flags.
// Classifies the pending token combinationally. Depends on stc_pkg.
module stc_token_state #(
    parameter int MAX_LEN = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_kind,
    input  logic [7:0]      i_char,
    output stc_pkg::t_token o_token
);

    localparam int CntW = $clog2(MAX_LEN + 1);
    localparam int LW   = (CntW > 8) ? CntW : 8;

    logic [CntW-1:0]          r_count, n_count;
    logic [stc_pkg::NRes-1:0] r_res, n_res;
    logic [stc_pkg::NSym-1:0] r_sym, n_sym;
    logic                     r_all_dig, n_all_dig;
    logic                     r_first_dig, n_first_dig;

    logic [LW-1:0]            w_cnt;
    logic [2:0]               w_pos;
    logic                     w_dig;
    logic                     w_is_res;
    logic                     w_is_sym;

    assign w_cnt = LW'(r_count);
    assign w_pos = r_count[2:0];
    assign w_dig = (i_char >= stc_pkg::DIGIT_LO) && (i_char <= stc_pkg::DIGIT_HI);

    always_comb begin
        w_is_res = 1'b0;
        w_is_sym = 1'b0;
        for (int i = 0; i < stc_pkg::NRes; i++) begin
            if (r_res[i] && (w_cnt == LW'(stc_pkg::RES_LEN[i]))) begin
                w_is_res = 1'b1;
            end
        end
        for (int i = 0; i < stc_pkg::NSym; i++) begin
            if (r_sym[i] && (w_cnt == LW'(stc_pkg::SYM_LEN[i]))) begin
                w_is_sym = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (w_is_res) begin
            o_token.token_class = stc_pkg::CLS_RESERVED;
        end else if (w_is_sym) begin
            o_token.token_class = stc_pkg::CLS_SYMBOL;
        end else if ((w_cnt != '0) && r_first_dig) begin
            o_token.token_class = r_all_dig ? stc_pkg::CLS_NUMBER : stc_pkg::CLS_NOT_ID;
        end else begin
            o_token.token_class = stc_pkg::CLS_IDENT;
        end
        o_token.token_length = (w_cnt > LW'(255)) ? 8'hFF : w_cnt[7:0];
    end

    always_comb begin
        n_count     = r_count;
        n_res       = r_res;
        n_sym       = r_sym;
        n_all_dig   = r_all_dig;
        n_first_dig = r_first_dig;
        if (i_step) begin
            if ((i_kind == stc_pkg::KIND_EOS) || (i_char == stc_pkg::SPACE_CODE)) begin
                n_count     = '0;
                n_res       = '1;
                n_sym       = '1;
                n_all_dig   = 1'b1;
                n_first_dig = 1'b0;
            end else begin
                for (int i = 0; i < stc_pkg::NRes; i++) begin
                    if (!((w_cnt < LW'(stc_pkg::RES_LEN[i])) &&
                          (stc_pkg::RES_STR[i][8*w_pos +: 8] == i_char))) begin
                        n_res[i] = 1'b0;
                    end
                end
                for (int i = 0; i < stc_pkg::NSym; i++) begin
                    if (!((w_cnt < LW'(stc_pkg::SYM_LEN[i])) &&
                          (stc_pkg::SYM_STR[i][8*w_pos[0] +: 8] == i_char))) begin
                        n_sym[i] = 1'b0;
                    end
                end
                if (r_count == '0) begin
                    n_first_dig = w_dig;
                end
                if (!w_dig) begin
                    n_all_dig = 1'b0;
                end
                if (r_count < CntW'(MAX_LEN)) begin
                    n_count = r_count + CntW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res       <= '1;
            r_sym       <= '1;
            r_all_dig   <= 1'b1;
            r_first_dig <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_res       <= n_res;
            r_sym       <= n_sym;
            r_all_dig   <= n_all_dig;
            r_first_dig <= n_first_dig;
        end
    end

endmodule

[rtl/core/stc_out_stage.sv]
// Result register for finished tokens with valid/ready handshake.
// Depends on stc_pkg.
module stc_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  stc_pkg::t_token i_token,
    input  logic            i_ready,
    output logic            o_free,
    output logic            o_valid,
    output stc_pkg::t_token o_token
);

    logic            r_valid, n_valid;
    stc_pkg::t_token r_token;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_token = r_token;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_token <= i_token;
        end
    end

endmodule

[rtl/core/space_token_classifier.sv]
// Top level of the space token classifier.
// Depends on stc_pkg, stc_token_state and stc_out_stage.
//
// Usage:
//   Input stream: one transfer per character. s_axis_tuser is the kind
//   (0 character, 1 end of statement), s_axis_tdata the character byte.
//   A space ends the pending token and produces one output transfer;
//   other characters and end of statement produce none. End of statement
//   drops the pending token.
//   Output stream: m_axis_tdata carries the token class (bits 2:0: 0 reserved,
//   1 special symbol, 2 number, 3 not identifier, 4 identifier) and the
//   token length (bits 10:3, saturating at MAX_LEN and 255).
//   Path: an accepted space passes from the input register into the result
//   register, which drives m_axis. Throughput: one character per cycle
//   while no space waits on a full result register, set by the input
//   register feeding the match flags and the result register in a single pass.
//   Reset: synchronous, active low; clears the pending token and both
//   valid flags.
//   Stall: while m_axis_tready is low a result holds; the input register
//   keeps taking characters that produce no result, and a space waits there
//   until the result register frees.
module space_token_classifier #(
    parameter int MAX_LEN = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [2:0] token_class, [10:3] token_length, zero pad
);

    logic            r_in_valid;
    logic            r_in_kind;
    logic [7:0]      r_in_char;

    logic            w_emit;
    logic            w_step;
    logic            w_out_free;
    stc_pkg::t_token w_token;
    stc_pkg::t_token w_out_token;

    assign w_emit        = (r_in_kind == stc_pkg::KIND_CHAR) &&
                           (r_in_char == stc_pkg::SPACE_CODE);
    assign w_step        = r_in_valid && (!w_emit || w_out_free);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= s_axis_tuser;
            r_in_char <= s_axis_tdata;
        end
    end

    stc_token_state #(
        .MAX_LEN (MAX_LEN)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_kind  (r_in_kind),
        .i_char  (r_in_char),
        .o_token (w_token)
    );

    stc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_emit),
        .i_token (w_token),
        .i_ready (m_axis_tready),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .o_token (w_out_token)
    );

    assign m_axis_tdata = {5'd0, w_out_token.token_length, w_out_token.token_class};

endmodule

[rtl/core/stc_checker.sv]
// Port-level checks for space_token_classifier, attached by bind.
// Depends on stc_pkg.
module stc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic [2:0] w_cls;
    logic [7:0] w_len;

    assign w_cls = m_axis_tdata[2:0];
    assign w_len = m_axis_tdata[10:3];

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transfer changed");

    a_res_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_cls == stc_pkg::CLS_RESERVED) |->
            (w_len == 8'd3) || (w_len == 8'd5) || (w_len == 8'd6))
        else $error("reserved word with wrong length");

    a_sym_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_cls == stc_pkg::CLS_SYMBOL) |->
            (w_len == 8'd1) || (w_len == 8'd2))
        else $error("special symbol with wrong length");

    a_num_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((w_cls == stc_pkg::CLS_NUMBER) ||
                          (w_cls == stc_pkg::CLS_NOT_ID)) |-> (w_len != 8'd0))
        else $error("digit token with zero length");

endmodule

bind space_token_classifier stc_checker u_stc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
